FILE: rtl/ascii_to_ps2_scancode_queue_top_assert.svh
// Assertion helpers shared by the datapath and controller RTL files.
// Both expect clk and rst_n to exist in the module that uses them.
`ifndef ASCII_TO_PS2_SCANCODE_QUEUE_TOP_ASSERT_SVH
`define ASCII_TO_PS2_SCANCODE_QUEUE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define A2PS2_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define A2PS2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/a2ps2_pkg.sv
package a2ps2_pkg;

  // Default queue depth in entries (one entry always stays empty)
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam logic [7:0] SHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SHIFT_BREAK = 8'hAA;
  localparam logic [7:0] BREAK_BIT   = 8'h80;

  // Byte selects of a push, in the order they are enqueued
  localparam logic [1:0] SEL_SHIFT_MAKE  = 2'd0;
  localparam logic [1:0] SEL_MAKE        = 2'd1;
  localparam logic [1:0] SEL_BREAK       = 2'd2;
  localparam logic [1:0] SEL_SHIFT_BREAK = 2'd3;

  typedef struct packed {
    logic [7:0] make;
    logic       shift;
  } map_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       push_en;
    logic [1:0] push_sel;
    logic       rd_en;
    logic       load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mapped;
    logic shift;
    logic out_free;
  } status_t;

  // Set 1 make codes of the letters a..z
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:  code = 8'h1E;
      5'd1:  code = 8'h30;
      5'd2:  code = 8'h2E;
      5'd3:  code = 8'h20;
      5'd4:  code = 8'h12;
      5'd5:  code = 8'h21;
      5'd6:  code = 8'h22;
      5'd7:  code = 8'h23;
      5'd8:  code = 8'h17;
      5'd9:  code = 8'h24;
      5'd10: code = 8'h25;
      5'd11: code = 8'h26;
      5'd12: code = 8'h32;
      5'd13: code = 8'h31;
      5'd14: code = 8'h18;
      5'd15: code = 8'h19;
      5'd16: code = 8'h10;
      5'd17: code = 8'h13;
      5'd18: code = 8'h1F;
      5'd19: code = 8'h14;
      5'd20: code = 8'h16;
      5'd21: code = 8'h2F;
      5'd22: code = 8'h11;
      5'd23: code = 8'h2D;
      5'd24: code = 8'h15;
      5'd25: code = 8'h2C;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Map an ASCII character to a make code; make of zero means unmapped
  function automatic map_t map_char(input logic [7:0] c);
    map_t       m;
    logic [7:0] off_lo;
    logic [7:0] off_up;
    off_lo  = c - 8'h61;
    off_up  = c - 8'h41;
    m.make  = 8'h00;
    m.shift = 1'b0;
    if (c >= 8'h31 && c <= 8'h39) begin
      m.make = c - 8'h2F;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m.make = letter_code(off_lo[4:0]);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      m.make  = letter_code(off_up[4:0]);
      m.shift = 1'b1;
    end else begin
      case (c)
        8'h08: m.make = 8'h0E;
        8'h09: m.make = 8'h0F;
        8'h0A: m.make = 8'h1C;
        8'h0D: m.make = 8'h1C;
        8'h1B: m.make = 8'h01;
        8'h20: m.make = 8'h39;
        8'h30: m.make = 8'h0B;
        8'h2D: m.make = 8'h0C;  // -
        8'h3D: m.make = 8'h0D;  // =
        8'h5B: m.make = 8'h1A;  // [
        8'h5D: m.make = 8'h1B;  // ]
        8'h3B: m.make = 8'h27;  // ;
        8'h27: m.make = 8'h28;  // '
        8'h60: m.make = 8'h29;  // `
        8'h5C: m.make = 8'h2B;  // backslash
        8'h2C: m.make = 8'h33;  // ,
        8'h2E: m.make = 8'h34;  // .
        8'h2F: m.make = 8'h35;  // /
        8'h3F: begin m.make = 8'h35; m.shift = 1'b1; end  // ?
        8'h21: begin m.make = 8'h02; m.shift = 1'b1; end  // !
        8'h40: begin m.make = 8'h03; m.shift = 1'b1; end  // @
        8'h2A: begin m.make = 8'h09; m.shift = 1'b1; end  // *
        8'h28: begin m.make = 8'h0A; m.shift = 1'b1; end  // (
        8'h29: begin m.make = 8'h0B; m.shift = 1'b1; end  // )
        8'h5F: begin m.make = 8'h0C; m.shift = 1'b1; end  // _
        8'h2B: begin m.make = 8'h0D; m.shift = 1'b1; end  // +
        8'h3A: begin m.make = 8'h27; m.shift = 1'b1; end  // :
        8'h22: begin m.make = 8'h28; m.shift = 1'b1; end  // "
        default: begin m.make = 8'h00; m.shift = 1'b0; end
      endcase
    end
    return m;
  endfunction

endpackage

FILE: rtl/a2ps2_ram.sv
module a2ps2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/a2ps2_datapath.sv
module a2ps2_datapath #(
  parameter int QUEUE_DEPTH = a2ps2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  a2ps2_pkg::cmd_t    cmd,
  output a2ps2_pkg::status_t status,
  input  logic               in_func,
  input  logic [7:0]         in_ascii_char,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_scancode,
  output logic               out_scancode_valid,
  output logic               out_char_mapped,
  output logic               out_irq_pending
);

  `include "ascii_to_ps2_scancode_queue_top_assert.svh"

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  logic             func_r;
  logic [7:0]       char_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r;
  logic [IDX_W-1:0] wr_idx_nxt;
  logic             pop_hit_r;
  logic             out_valid_r;
  logic [7:0]       out_scancode_r;
  logic             out_scancode_valid_r;
  logic             out_char_mapped_r;
  logic             out_irq_pending_r;

  a2ps2_pkg::map_t  map;
  logic             mapped;
  logic             not_empty;
  logic             full;
  logic             push_ok;
  logic             pop_ok;
  logic [7:0]       push_data;
  logic [7:0]       ram_rdata;

  // Translate the held character
  assign map    = a2ps2_pkg::map_char(char_r);
  assign mapped = !func_r && (map.make != 8'h00);

  // Queue occupancy, one slot kept empty
  assign wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_idx_nxt = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;
  assign not_empty  = (rd_idx_r != wr_idx_r);
  assign full       = (wr_idx_nxt == rd_idx_r);
  assign push_ok    = cmd.push_en && !full;
  assign pop_ok     = cmd.rd_en && not_empty;

  // Select the byte of the push sequence
  always_comb begin
    case (cmd.push_sel)
      a2ps2_pkg::SEL_SHIFT_MAKE: push_data = a2ps2_pkg::SHIFT_MAKE;
      a2ps2_pkg::SEL_MAKE:       push_data = map.make;
      a2ps2_pkg::SEL_BREAK:      push_data = map.make | a2ps2_pkg::BREAK_BIT;
      a2ps2_pkg::SEL_SHIFT_BREAK: push_data = a2ps2_pkg::SHIFT_BREAK;
      default:                   push_data = 8'h00;
    endcase
  end

  a2ps2_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_idx_r),
    .wdata (push_data),
    .re    (pop_ok),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      char_r <= in_ascii_char;
    end
  end

  // Advance the queue indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      wr_idx_r  <= '0;
      pop_hit_r <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_idx_r <= wr_idx_nxt;
      end
      if (pop_ok) begin
        rd_idx_r <= rd_idx_nxt;
      end
      if (cmd.load_item) begin
        pop_hit_r <= 1'b0;
      end else if (cmd.rd_en) begin
        pop_hit_r <= not_empty;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_scancode_r       <= pop_hit_r ? ram_rdata : 8'h00;
      out_scancode_valid_r <= pop_hit_r;
      out_char_mapped_r    <= mapped;
      out_irq_pending_r    <= not_empty;
    end
  end

  assign status.mapped   = mapped;
  assign status.shift    = map.shift;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_scancode       = out_scancode_r;
  assign out_scancode_valid = out_scancode_valid_r;
  assign out_char_mapped    = out_char_mapped_r;
  assign out_irq_pending    = out_irq_pending_r;

  `A2PS2_ASSERT_NEXT(a_full_no_advance, cmd.push_en && full, $stable(wr_idx_r),
    "write index moved on a push into a full queue")
  `A2PS2_ASSERT_NEXT(a_push_not_empty, push_ok, rd_idx_r != wr_idx_r,
    "queue empty right after a stored push byte")
  `A2PS2_ASSERT_SAME(a_pop_excl_mapped, out_valid_r && out_scancode_valid_r,
    !out_char_mapped_r, "result both popped a code and mapped a character")
  `A2PS2_ASSERT_SAME(a_miss_zero, out_valid_r && !out_scancode_valid_r,
    out_scancode_r == 8'h00, "scancode nonzero without a popped code")

endmodule

FILE: rtl/a2ps2_ctrl.sv
module a2ps2_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_func,
  output logic               in_ready,
  input  a2ps2_pkg::status_t status,
  output a2ps2_pkg::cmd_t    cmd
);

  `include "ascii_to_ps2_scancode_queue_top_assert.svh"

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PUSH   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [1:0] step_r;
  logic [1:0] step_nxt;
  logic       step_used;

  // Shift bytes only go out for shifted characters
  assign step_used = status.shift ||
                     (step_r == a2ps2_pkg::SEL_MAKE) ||
                     (step_r == a2ps2_pkg::SEL_BREAK);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.push_en   = 1'b0;
    cmd.push_sel  = step_r;  // step order matches push byte order
    cmd.rd_en     = 1'b0;
    cmd.load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          step_nxt      = a2ps2_pkg::SEL_SHIFT_MAKE;
          state_nxt     = in_func ? ST_READ : ST_PUSH;
        end
      end
      ST_PUSH: begin
        // Walk the four byte slots of a mapped character, skip unused ones
        cmd.push_en = status.mapped && step_used;
        step_nxt    = step_r + 1'b1;
        if (!status.mapped || step_r == a2ps2_pkg::SEL_SHIFT_BREAK) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // Wait for the output register to free up
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= a2ps2_pkg::SEL_SHIFT_MAKE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `A2PS2_ASSERT_SAME(a_one_cmd, 1'b1,
    $onehot0({cmd.load_item, cmd.push_en, cmd.rd_en, cmd.load_out}),
    "more than one datapath command in a cycle")
  `A2PS2_ASSERT_NEXT(a_read_then_result, cmd.rd_en, state_r == ST_RESULT,
    "read not followed by the result state")
  `A2PS2_ASSERT_NEXT(a_result_then_idle, cmd.load_out, in_ready,
    "not ready for a new item after loading a result")

endmodule

FILE: rtl/ascii_to_ps2_scancode_queue_top.sv
// ASCII to PS/2 Set 1 scancode queue.
// Input channel (in_valid/in_ready): in_func = 0 injects in_ascii_char, which
// is mapped to a Set 1 make code and enqueued as optional shift make, make,
// break and optional shift break; in_func = 1 pops one code from the queue.
// Output channel (out_valid/out_ready): one result per input item with the
// popped code and its valid flag, the mapped flag of an injection, and
// out_irq_pending, high while the queue still holds codes.
// Sequence after accept: a mapped injection walks the four byte slots in
// ST_PUSH (through the single write port of the queue RAM), an unmapped one
// leaves ST_PUSH after its first slot, a read passes ST_READ (one registered
// RAM read); each then loads its result from ST_RESULT. One item at a time:
// the next item is accepted only once the previous result is loaded; the
// queue RAM write port and the sequencer set this pace.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and processed, and its result waits until the register
// frees up. Reset (rst_n low, synchronous) empties the queue by clearing both
// indices; queue contents are not cleared. The queue holds QUEUE_DEPTH - 1
// codes; bytes pushed into a full queue are dropped one by one.
module ascii_to_ps2_scancode_queue_top #(
  parameter int QUEUE_DEPTH = a2ps2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_ascii_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_scancode,
  output logic       out_scancode_valid,
  output logic       out_char_mapped,
  output logic       out_irq_pending
);

  a2ps2_pkg::cmd_t    cmd;
  a2ps2_pkg::status_t status;

  a2ps2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  a2ps2_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_func            (in_func),
    .in_ascii_char      (in_ascii_char),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_scancode       (out_scancode),
    .out_scancode_valid (out_scancode_valid),
    .out_char_mapped    (out_char_mapped),
    .out_irq_pending    (out_irq_pending)
  );

endmodule

FILE: sim/ascii_to_ps2_scancode_queue_top_test.sv
`timescale 1ns / 1ps

module ascii_to_ps2_scancode_queue_top_test;

  localparam logic FUNC_INJECT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  localparam int   DEPTH       = a2ps2_pkg::QUEUE_DEPTH_DEF;
  localparam int   PTR_W       = $clog2(DEPTH);
  localparam int   STALL_LIMIT = 1000;
  localparam int   PHASE_LEN   = 120;
  localparam int   PHASES      = 6;

  // Set 1 make codes of a..z, letter a in the lowest byte
  localparam logic [26*8-1:0] LETTER_MAKE = {
    8'h2C, 8'h15, 8'h2D, 8'h11, 8'h2F, 8'h16, 8'h14, 8'h1F, 8'h13, 8'h10,
    8'h19, 8'h18, 8'h31, 8'h32, 8'h26, 8'h25, 8'h24, 8'h17, 8'h23, 8'h22,
    8'h21, 8'h12, 8'h20, 8'h2E, 8'h30, 8'h1E
  };

  typedef struct packed {
    logic       shift;
    logic [7:0] make;
  } key_t;

  typedef struct packed {
    logic [7:0] scancode;
    logic       scancode_valid;
    logic       char_mapped;
    logic       irq_pending;
  } scan_result_t;

  typedef struct packed {
    logic         func;
    logic [7:0]   ch;
    logic         typed;
    scan_result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [7:0] in_ascii_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_scancode;
  logic       out_scancode_valid;
  logic       out_char_mapped;
  logic       out_irq_pending;

  // Predicted keyboard queue
  logic [7:0] code_mem [0:DEPTH-1];
  int         rd_ptr;
  int         wr_ptr;

  scan_result_t pending_results [$];
  stim_row_t    key_script [$];
  int           error_count;
  int           stall_cycles;
  logic         calm;

  ascii_to_ps2_scancode_queue_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_ascii_char     (in_ascii_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scancode      (out_scancode),
    .out_scancode_valid(out_scancode_valid),
    .out_char_mapped   (out_char_mapped),
    .out_irq_pending   (out_irq_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Translate a character to its make code; make of zero means no key
  function automatic key_t keymap_lookup(input logic [7:0] c);
    key_t k;
    k = '0;
    if (c >= 8'h31 && c <= 8'h39) begin
      k.make = c - 8'h31 + 8'h02;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      k.make = LETTER_MAKE[8*(c - 8'h61) +: 8];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      k.make  = LETTER_MAKE[8*(c - 8'h41) +: 8];
      k.shift = 1'b1;
    end else begin
      case (c)
        8'h08: k.make = 8'h0E;  // backspace
        8'h09: k.make = 8'h0F;  // tab
        8'h0A: k.make = 8'h1C;  // line feed
        8'h0D: k.make = 8'h1C;  // carriage return
        8'h1B: k.make = 8'h01;  // escape
        8'h20: k.make = 8'h39;  // space
        8'h30: k.make = 8'h0B;  // digit zero
        8'h2D: k.make = 8'h0C;
        8'h3D: k.make = 8'h0D;
        8'h5B: k.make = 8'h1A;
        8'h5D: k.make = 8'h1B;
        8'h3B: k.make = 8'h27;
        8'h27: k.make = 8'h28;
        8'h60: k.make = 8'h29;
        8'h5C: k.make = 8'h2B;
        8'h2C: k.make = 8'h33;
        8'h2E: k.make = 8'h34;
        8'h2F: k.make = 8'h35;
        // shifted symbols
        8'h3F: k = '{1'b1, 8'h35};
        8'h21: k = '{1'b1, 8'h02};
        8'h40: k = '{1'b1, 8'h03};
        8'h2A: k = '{1'b1, 8'h09};
        8'h28: k = '{1'b1, 8'h0A};
        8'h29: k = '{1'b1, 8'h0B};
        8'h5F: k = '{1'b1, 8'h0C};
        8'h2B: k = '{1'b1, 8'h0D};
        8'h3A: k = '{1'b1, 8'h27};
        8'h22: k = '{1'b1, 8'h28};
        default: k = '0;
      endcase
    end
    return k;
  endfunction

  // Append one code, drop it when only the spare slot is left
  function automatic void queue_code(input logic [7:0] code);
    int nxt;
    nxt = (wr_ptr + 1) % DEPTH;
    if (nxt != rd_ptr) begin
      code_mem[wr_ptr[PTR_W-1:0]] = code;
      wr_ptr = nxt;
    end
  endfunction

  function automatic scan_result_t predict_scan_result(input logic f, input logic [7:0] c);
    scan_result_t r;
    key_t         k;
    r = '0;
    if (f == FUNC_INJECT) begin
      k = keymap_lookup(c);
      if (k.make != 8'h00) begin
        r.char_mapped = 1'b1;
        if (k.shift) queue_code(a2ps2_pkg::SHIFT_MAKE);
        queue_code(k.make);
        queue_code(k.make | a2ps2_pkg::BREAK_BIT);
        if (k.shift) queue_code(a2ps2_pkg::SHIFT_BREAK);
      end
    end else if (rd_ptr != wr_ptr) begin
      r.scancode       = code_mem[rd_ptr[PTR_W-1:0]];
      r.scancode_valid = 1'b1;
      rd_ptr           = (rd_ptr + 1) % DEPTH;
    end
    r.irq_pending = (rd_ptr != wr_ptr);
    return r;
  endfunction

  function automatic void add_row(input logic f, input logic [7:0] c, input logic typed,
                                  input logic [7:0] code, input logic v, input logic m,
                                  input logic irq);
    stim_row_t row;
    row.func = f;
    row.ch   = c;
    row.typed = typed;
    row.want = '{code, v, m, irq};
    key_script.push_back(row);
  endfunction

  // Present one item, hold it until the transfer, then record its result
  task automatic send_item(input logic f, input logic [7:0] c, input logic typed,
                           input scan_result_t want);
    scan_result_t got;
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_ascii_char <= c;
    do @(posedge clk); while (!in_ready);
    got = predict_scan_result(f, c);
    pending_results.push_back(typed ? want : got);
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_scancode, out_scancode_valid, out_char_mapped, out_irq_pending};
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: code %02h valid %0b mapped %0b irq %0b",
                   seen.scancode, seen.scancode_valid, seen.char_mapped, seen.irq_pending);
      end else begin
        want = pending_results.pop_front();
        if (seen.scancode !== want.scancode || seen.scancode_valid !== want.scancode_valid ||
            seen.char_mapped !== want.char_mapped || seen.irq_pending !== want.irq_pending)
        begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: want %02h %0b %0b %0b, got %02h %0b %0b %0b",
                     want.scancode, want.scancode_valid, want.char_mapped, want.irq_pending,
                     seen.scancode, seen.scancode_valid, seen.char_mapped, seen.irq_pending);
        end
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t    row;
    scan_result_t none;
    key_t         k;
    logic         f;
    logic [7:0]   c;
    int           inject_pct;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_INJECT;
    in_ascii_char <= 8'h00;
    out_ready     <= 1'b0;
    calm          = 1'b0;
    error_count   = 0;
    stall_cycles  <= 0;
    rd_ptr        = 0;
    wr_ptr        = 0;
    none          = '0;

    // Directed part: empty reads, unmapped extremes, shifted and plain keys
    add_row(FUNC_READ,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h7F, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h61, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
    add_row(FUNC_READ,   8'h00, 1'b1, 8'h1E, 1'b1, 1'b0, 1'b1);
    add_row(FUNC_READ,   8'hFF, 1'b1, 8'h9E, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_READ,   8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h5A, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
    add_row(FUNC_READ,   8'h00, 1'b1, a2ps2_pkg::SHIFT_MAKE, 1'b1, 1'b0, 1'b1);
    add_row(FUNC_READ,   8'h00, 1'b1, 8'h2C, 1'b1, 1'b0, 1'b1);
    add_row(FUNC_READ,   8'h00, 1'b1, 8'hAC, 1'b1, 1'b0, 1'b1);
    add_row(FUNC_READ,   8'h00, 1'b1, a2ps2_pkg::SHIFT_BREAK, 1'b1, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h08, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h1B, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h20, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h30, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h39, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h7A, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h41, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h5C, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h22, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_INJECT, 8'h3F, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_READ,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(FUNC_READ,   8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_script[i]) begin
      row = key_script[i];
      send_item(row.func, row.ch, row.typed, row.want);
    end

    // Random part: alternate fill and drain phases so the queue hits full
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: inject_pct = 97;
        1: inject_pct = 8;
        2: inject_pct = 95;
        3: inject_pct = 55;
        4: inject_pct = 5;
        default: inject_pct = 80;
      endcase
      calm = (p == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        f = ($urandom_range(99) < inject_pct) ? FUNC_INJECT : FUNC_READ;
        if ($urandom_range(99) < 10) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          do begin
            c = 8'($urandom_range(0, 255));
            k = keymap_lookup(c);
          end while (k.make == 8'h00);
        end
        send_item(f, c, 1'b0, none);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain the remaining results, then give late extras time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/a2ps2_pkg.sv
rtl/a2ps2_ram.sv
rtl/a2ps2_datapath.sv
rtl/a2ps2_ctrl.sv
rtl/ascii_to_ps2_scancode_queue_top.sv
sim/ascii_to_ps2_scancode_queue_top_test.sv
